[hdl/ttx_pkg.sv]
`default_nettype none
package ttx_pkg;

  localparam int unsigned MEM_BYTES_DEF = 256;
  localparam int unsigned GP_REGS       = 7;

  localparam logic [3:0] REG_EAX = 4'd0;
  localparam logic [3:0] REG_EDX = 4'd3;
  localparam logic [3:0] REG_ESP = 4'd7;
  localparam logic [3:0] REG_EIP = 4'd8;

  localparam logic [31:0] FLAG_CLEAR_MASK = 32'h0000_08D5;
  localparam logic [31:0] FLAG_ZF         = 32'h0000_0040;
  localparam logic [31:0] FLAG_SF         = 32'h0000_0080;
  localparam logic [31:0] FLAG_PF         = 32'h0000_0004;
  localparam logic [31:0] FLAG_CF         = 32'h0000_0001;
  localparam logic [31:0] FLAGS_RESET     = 32'h0000_0002;
  localparam logic [31:0] ESP_RESET       = 32'h0000_00FF;
  localparam logic [31:0] STACK_STEP      = 32'd4;

  typedef enum logic [4:0] {
    OP_MOV  = 5'd0,  OP_ADD  = 5'd1,  OP_SUB  = 5'd2,  OP_MUL  = 5'd3,
    OP_DIV  = 5'd4,  OP_AND  = 5'd5,  OP_OR   = 5'd6,  OP_XOR  = 5'd7,
    OP_NOT  = 5'd8,  OP_SHL  = 5'd9,  OP_SHR  = 5'd10, OP_INC  = 5'd11,
    OP_DEC  = 5'd12, OP_CMP  = 5'd13, OP_TEST = 5'd14, OP_PUSH = 5'd15,
    OP_POP  = 5'd16, OP_NOP  = 5'd17, OP_BAD  = 5'd31
  } op_t;

  typedef enum logic [1:0] {
    STAT_DONE = 2'd0,
    STAT_DIVZ = 2'd1,
    STAT_UNK  = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_READ, S_EXEC, S_MUL_LO, S_MUL_HI, S_DIV_WAIT,
    S_DIV_LO, S_DIV_HI, S_MOD_RCP, S_MOD_MUL, S_MOD_FIX, S_PUSH, S_POP,
    S_POP_WB, S_FIN
  } back_state_t;

  typedef struct packed {
    logic [4:0]  action;
    logic        first_is_register;
    logic [3:0]  first_register;
    logic [31:0] first_immediate;
    logic        second_is_register;
    logic [3:0]  second_register;
    logic [31:0] second_immediate;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] result_value;
    logic [31:0] result_high;
    logic [31:0] flags_word;
    logic [31:0] stack_pointer;
  } out_item_t;

  // classified instruction as held in the queue between front and back
  typedef struct packed {
    op_t         op;
    logic        a_reg;
    logic [3:0]  a_idx;
    logic [31:0] a_imm;
    logic        b_reg;
    logic [3:0]  b_idx;
    logic [31:0] b_imm;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

  typedef struct packed {
    logic clearing;
    logic div_busy;
  } back_stat_t;

endpackage
`default_nettype wire

[hdl/ttx_front.sv]
`default_nettype none
module ttx_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire logic              hold,
  output logic                   full,
  input  wire ttx_pkg::in_item_t in_data,
  output ttx_pkg::q_head_t       head,
  input  wire logic              head_pop
);

  ttx_pkg::q_item_t cls;
  ttx_pkg::q_item_t q_mem_r [0:1];
  logic             wr_ptr_r, rd_ptr_r;
  logic [1:0]       count_r, count_nxt;
  logic             acc;

  // classify: map unknown actions to OP_BAD, fold out-of-range register indexes into immediate zero
  always_comb begin
    cls.op    = (in_data.action <= ttx_pkg::OP_NOP) ? ttx_pkg::op_t'(in_data.action)
                                                     : ttx_pkg::OP_BAD;
    cls.a_reg = in_data.first_is_register && (in_data.first_register <= ttx_pkg::REG_EIP);
    cls.a_idx = in_data.first_register;
    cls.a_imm = in_data.first_is_register ? '0 : in_data.first_immediate;
    cls.b_reg = in_data.second_is_register && (in_data.second_register <= ttx_pkg::REG_EIP);
    cls.b_idx = in_data.second_register;
    cls.b_imm = in_data.second_is_register ? '0 : in_data.second_immediate;
  end

  assign full       = (count_r == 2'd2) || hold;
  assign acc        = push && !full;
  assign head.valid = (count_r != 2'd0);
  assign head.item  = q_mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (acc && !head_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (!acc && head_pop) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (acc) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (head_pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      q_mem_r[wr_ptr_r] <= cls;
    end
  end

endmodule
`default_nettype wire

[hdl/ttx_div.sv]
`default_nettype none
module ttx_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [31:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [31:0]      quotient,
  output logic [31:0]      remainder
);

  logic        busy_r, done_r;
  logic [4:0]  cnt_r;
  logic [31:0] dvd_r, rem_r, dsr_r;
  logic [32:0] trial;

  // one quotient bit a cycle, restoring
  assign trial     = {rem_r, dvd_r[31]} - {1'b0, dsr_r};
  assign busy      = busy_r;
  assign done      = done_r;
  assign quotient  = dvd_r;
  assign remainder = rem_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      if (!trial[32]) begin
        rem_r <= trial[31:0];
        dvd_r <= {dvd_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], dvd_r[31]};
        dvd_r <= {dvd_r[30:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

[hdl/ttx_back.sv]
`default_nettype none
module ttx_back #(
  parameter int unsigned MEM_BYTES = ttx_pkg::MEM_BYTES_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire ttx_pkg::q_head_t head,
  output logic                  head_pop,
  output ttx_pkg::back_stat_t   stat,
  output logic                  empty,
  input  wire logic             pop,
  output ttx_pkg::out_item_t    out_data
);

  localparam int unsigned AW = $clog2(MEM_BYTES);
  localparam logic [AW-1:0] LAST_ADDR = AW'(MEM_BYTES - 1);
  localparam logic [31:0]   MEM_SIZE  = 32'(MEM_BYTES);
  // floor(2^32 / MEM_BYTES); the quotient estimate is at most one short
  localparam logic [31:0]   RECIP     = 32'((64'd1 << 32) / 64'(MEM_BYTES));

  ttx_pkg::back_state_t state_r, state_nxt;

  ttx_pkg::q_item_t it_r;
  logic [31:0] opa_r, opb_r, val_r, hi_r, flags_r, esp_r, eip_r, sp_r;
  logic [31:0] qm_r, rem_est;
  logic [1:0]  status_r;
  logic [63:0] prod_r;
  logic [2:0]  cnt_r;
  logic [AW-1:0] addr_r, clr_r;

  logic [31:0] gp_mem [0:ttx_pkg::GP_REGS-1];
  logic [31:0] gp_a_q, gp_b_q;
  logic [2:0]  gp_ra, gp_rb, gp_wa;
  logic        gp_we;
  logic [31:0] gp_wd;

  logic [7:0]    stk_mem [0:MEM_BYTES-1];
  logic [7:0]    st_q, st_wd;
  logic [AW-1:0] st_ra, st_wa, eff_addr;
  logic          st_we;
  logic [32:0]   sum_k;

  logic        div_start, div_busy, div_done;
  logic [31:0] div_a, div_b, div_q, div_r;

  logic [31:0] alu_val, alu_flags, opa_nxt, opb_nxt, wb_val;
  logic        sets_flags, writes_dest, wb_en;
  logic        out_ld, ovalid_r;
  ttx_pkg::out_item_t out_r;

  function automatic logic [31:0] reg_pick(logic [3:0] idx, logic [31:0] mem_q,
                                           logic [31:0] esp, logic [31:0] eip);
    logic [31:0] v;
    if (idx == ttx_pkg::REG_ESP) begin
      v = esp;
    end else if (idx == ttx_pkg::REG_EIP) begin
      v = eip;
    end else begin
      v = mem_q;
    end
    return v;
  endfunction

  ttx_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_a),
    .divisor   (div_b),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  assign stat.clearing = (state_r == ttx_pkg::S_CLEAR);
  assign stat.div_busy = div_busy;

  // operand select after the register file read
  assign opa_nxt = it_r.a_reg ? reg_pick(it_r.a_idx, gp_a_q, esp_r, eip_r) : it_r.a_imm;
  assign opb_nxt = it_r.b_reg ? reg_pick(it_r.b_idx, gp_b_q, esp_r, eip_r) : it_r.b_imm;

  // stack byte address; a carry out of esp+k lands below MEM_BYTES directly
  assign sum_k    = {1'b0, sp_r} + 33'(cnt_r[1:0]);
  assign eff_addr = sum_k[32] ? sum_k[AW-1:0] : addr_r;

  // remainder estimate of sp modulo MEM_BYTES, below twice MEM_BYTES
  assign rem_est = sp_r - qm_r;

  always_comb begin
    alu_val     = '0;
    sets_flags  = 1'b0;
    writes_dest = 1'b1;
    unique case (it_r.op)
      ttx_pkg::OP_MOV:  alu_val = opb_r;
      ttx_pkg::OP_ADD:  begin alu_val = opa_r + opb_r; sets_flags = 1'b1; end
      ttx_pkg::OP_SUB:  begin alu_val = opa_r - opb_r; sets_flags = 1'b1; end
      ttx_pkg::OP_CMP:  begin
        alu_val = opa_r - opb_r; sets_flags = 1'b1; writes_dest = 1'b0;
      end
      ttx_pkg::OP_AND:  begin alu_val = opa_r & opb_r; sets_flags = 1'b1; end
      ttx_pkg::OP_TEST: begin
        alu_val = opa_r & opb_r; sets_flags = 1'b1; writes_dest = 1'b0;
      end
      ttx_pkg::OP_OR:   begin alu_val = opa_r | opb_r; sets_flags = 1'b1; end
      ttx_pkg::OP_XOR:  begin alu_val = opa_r ^ opb_r; sets_flags = 1'b1; end
      ttx_pkg::OP_NOT:  alu_val = ~opa_r;
      ttx_pkg::OP_SHL:  begin alu_val = opa_r << opb_r[4:0]; sets_flags = 1'b1; end
      ttx_pkg::OP_SHR:  begin alu_val = opa_r >> opb_r[4:0]; sets_flags = 1'b1; end
      ttx_pkg::OP_INC:  begin alu_val = opa_r + 32'd1; sets_flags = 1'b1; end
      ttx_pkg::OP_DEC:  begin alu_val = opa_r - 32'd1; sets_flags = 1'b1; end
      default:          writes_dest = 1'b0;
    endcase
    alu_flags = flags_r & ~ttx_pkg::FLAG_CLEAR_MASK;
    if (alu_val == '0) begin
      alu_flags = alu_flags | ttx_pkg::FLAG_ZF;
    end
    if (alu_val[31]) begin
      alu_flags = alu_flags | ttx_pkg::FLAG_SF;
    end
    if (!(^alu_val[7:0])) begin
      alu_flags = alu_flags | ttx_pkg::FLAG_PF;
    end
    if (((it_r.op == ttx_pkg::OP_SUB) || (it_r.op == ttx_pkg::OP_CMP)) && (opa_r < opb_r)) begin
      alu_flags = alu_flags | ttx_pkg::FLAG_CF;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ttx_pkg::S_CLEAR: if (clr_r == LAST_ADDR) state_nxt = ttx_pkg::S_IDLE;
      ttx_pkg::S_IDLE:  if (head.valid) state_nxt = ttx_pkg::S_READ;
      ttx_pkg::S_READ:  state_nxt = ttx_pkg::S_EXEC;
      ttx_pkg::S_EXEC: begin
        unique case (it_r.op)
          ttx_pkg::OP_MUL:  state_nxt = ttx_pkg::S_MUL_LO;
          ttx_pkg::OP_DIV:  state_nxt = (opb_r == '0) ? ttx_pkg::S_FIN : ttx_pkg::S_DIV_WAIT;
          ttx_pkg::OP_PUSH: state_nxt = ttx_pkg::S_MOD_RCP;
          ttx_pkg::OP_POP:  state_nxt = ttx_pkg::S_MOD_RCP;
          default:          state_nxt = ttx_pkg::S_FIN;
        endcase
      end
      ttx_pkg::S_MUL_LO:   state_nxt = ttx_pkg::S_MUL_HI;
      ttx_pkg::S_MUL_HI:   state_nxt = ttx_pkg::S_FIN;
      ttx_pkg::S_DIV_WAIT: if (div_done) state_nxt = ttx_pkg::S_DIV_LO;
      ttx_pkg::S_DIV_LO:   state_nxt = ttx_pkg::S_DIV_HI;
      ttx_pkg::S_DIV_HI:   state_nxt = ttx_pkg::S_FIN;
      ttx_pkg::S_MOD_RCP:  state_nxt = ttx_pkg::S_MOD_MUL;
      ttx_pkg::S_MOD_MUL:  state_nxt = ttx_pkg::S_MOD_FIX;
      ttx_pkg::S_MOD_FIX: begin
        state_nxt = (it_r.op == ttx_pkg::OP_PUSH) ? ttx_pkg::S_PUSH : ttx_pkg::S_POP;
      end
      ttx_pkg::S_PUSH:   if (cnt_r == 3'd3) state_nxt = ttx_pkg::S_FIN;
      ttx_pkg::S_POP:    if (cnt_r == 3'd4) state_nxt = ttx_pkg::S_POP_WB;
      ttx_pkg::S_POP_WB: state_nxt = ttx_pkg::S_FIN;
      ttx_pkg::S_FIN:    if (out_ld) state_nxt = ttx_pkg::S_IDLE;
      default:           state_nxt = ttx_pkg::S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    head_pop  = 1'b0;
    gp_ra     = '0;
    gp_rb     = '0;
    gp_we     = 1'b0;
    gp_wa     = '0;
    gp_wd     = '0;
    st_we     = 1'b0;
    st_wa     = eff_addr;
    st_wd     = '0;
    st_ra     = eff_addr;
    div_start = 1'b0;
    div_a     = opa_r;
    div_b     = opb_r;
    wb_en     = 1'b0;
    wb_val    = alu_val;
    unique case (state_r)
      ttx_pkg::S_CLEAR: begin
        st_we = 1'b1;
        st_wa = clr_r;
        gp_we = (clr_r < AW'(ttx_pkg::GP_REGS));
        gp_wa = clr_r[2:0];
      end
      ttx_pkg::S_IDLE: begin
        head_pop = head.valid;
        gp_ra    = (head.item.a_idx < 4'(ttx_pkg::GP_REGS)) ? head.item.a_idx[2:0] : 3'd0;
        gp_rb    = (head.item.b_idx < 4'(ttx_pkg::GP_REGS)) ? head.item.b_idx[2:0] : 3'd0;
      end
      ttx_pkg::S_EXEC: begin
        wb_en     = it_r.a_reg && writes_dest;
        div_start = (it_r.op == ttx_pkg::OP_DIV) && (opb_r != '0);
      end
      ttx_pkg::S_MUL_LO: begin
        gp_we = 1'b1; gp_wa = ttx_pkg::REG_EAX[2:0]; gp_wd = prod_r[31:0];
      end
      ttx_pkg::S_MUL_HI: begin
        gp_we = 1'b1; gp_wa = ttx_pkg::REG_EDX[2:0]; gp_wd = prod_r[63:32];
      end
      ttx_pkg::S_DIV_LO: begin
        gp_we = 1'b1; gp_wa = ttx_pkg::REG_EAX[2:0]; gp_wd = div_q;
      end
      ttx_pkg::S_DIV_HI: begin
        gp_we = 1'b1; gp_wa = ttx_pkg::REG_EDX[2:0]; gp_wd = div_r;
      end
      ttx_pkg::S_PUSH: begin
        st_we = 1'b1;
        st_wd = opa_r[8*cnt_r[1:0] +: 8];
      end
      ttx_pkg::S_POP_WB: begin
        wb_en  = it_r.a_reg;
        wb_val = val_r;
      end
      default: ;
    endcase
    // register destinations below esp go to the register memory
    if (wb_en && (it_r.a_idx < 4'(ttx_pkg::GP_REGS))) begin
      gp_we = 1'b1;
      gp_wa = it_r.a_idx[2:0];
      gp_wd = wb_val;
    end
  end

  assign out_ld = (state_r == ttx_pkg::S_FIN) && (!ovalid_r || pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ttx_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // architectural control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r    <= '0;
      flags_r  <= ttx_pkg::FLAGS_RESET;
      esp_r    <= ttx_pkg::ESP_RESET;
      eip_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      if (state_r == ttx_pkg::S_CLEAR) begin
        clr_r <= clr_r + AW'(1);
      end
      if ((state_r == ttx_pkg::S_EXEC) && sets_flags) begin
        flags_r <= alu_flags;
      end
      // a register write to esp or eip takes priority over the stack and step updates
      if (wb_en && (it_r.a_idx == ttx_pkg::REG_ESP)) begin
        esp_r <= wb_val;
      end else if (state_r == ttx_pkg::S_POP_WB) begin
        esp_r <= sp_r + ttx_pkg::STACK_STEP;
      end else if ((state_r == ttx_pkg::S_EXEC) && (it_r.op == ttx_pkg::OP_PUSH)) begin
        esp_r <= esp_r - ttx_pkg::STACK_STEP;
      end
      if (wb_en && (it_r.a_idx == ttx_pkg::REG_EIP)) begin
        eip_r <= wb_val;
      end else if (state_r == ttx_pkg::S_READ) begin
        eip_r <= eip_r + 32'd1;
      end
      if (out_ld) begin
        ovalid_r <= 1'b1;
      end else if (pop) begin
        ovalid_r <= 1'b0;
      end
    end
  end

  // working registers of one item
  always_ff @(posedge clk) begin
    if (head_pop) begin
      it_r <= head.item;
    end
    unique case (state_r)
      ttx_pkg::S_READ: begin
        opa_r    <= opa_nxt;
        opb_r    <= opb_nxt;
        val_r    <= '0;
        hi_r     <= '0;
        status_r <= ttx_pkg::STAT_DONE;
      end
      ttx_pkg::S_EXEC: begin
        cnt_r <= '0;
        unique case (it_r.op)
          ttx_pkg::OP_MUL:  prod_r <= opa_r * opb_r;
          ttx_pkg::OP_DIV:  if (opb_r == '0) status_r <= ttx_pkg::STAT_DIVZ;
          ttx_pkg::OP_PUSH: begin
            val_r <= opa_r;
            sp_r  <= esp_r - ttx_pkg::STACK_STEP;
          end
          ttx_pkg::OP_POP:  sp_r <= esp_r;
          ttx_pkg::OP_BAD:  status_r <= ttx_pkg::STAT_UNK;
          default:          val_r <= alu_val;
        endcase
      end
      ttx_pkg::S_MUL_LO: val_r <= prod_r[31:0];
      ttx_pkg::S_MUL_HI: hi_r  <= prod_r[63:32];
      ttx_pkg::S_DIV_LO: val_r <= div_q;
      ttx_pkg::S_DIV_HI: hi_r  <= div_r;
      // reduce sp modulo MEM_BYTES by reciprocal multiplication
      ttx_pkg::S_MOD_RCP: prod_r <= {32'd0, sp_r} * {32'd0, RECIP};
      ttx_pkg::S_MOD_MUL: qm_r   <= 32'(prod_r[63:32] * MEM_SIZE);
      ttx_pkg::S_MOD_FIX: begin
        addr_r <= (rem_est >= MEM_SIZE) ? AW'(rem_est - MEM_SIZE) : AW'(rem_est);
      end
      ttx_pkg::S_PUSH: begin
        cnt_r  <= cnt_r + 3'd1;
        addr_r <= (addr_r == LAST_ADDR) ? '0 : addr_r + AW'(1);
      end
      ttx_pkg::S_POP: begin
        cnt_r  <= cnt_r + 3'd1;
        addr_r <= (addr_r == LAST_ADDR) ? '0 : addr_r + AW'(1);
        if (cnt_r != 3'd0) begin
          val_r[8*(2'(cnt_r - 3'd1)) +: 8] <= st_q;
        end
      end
      default: ;
    endcase
  end

  // register memory for the seven registers below esp, two registered read ports
  always_ff @(posedge clk) begin
    if (gp_we) begin
      gp_mem[gp_wa] <= gp_wd;
    end
    gp_a_q <= gp_mem[gp_ra];
    gp_b_q <= gp_mem[gp_rb];
  end

  // byte stack memory
  always_ff @(posedge clk) begin
    if (st_we) begin
      stk_mem[st_wa] <= st_wd;
    end
    st_q <= stk_mem[st_ra];
  end

  always_ff @(posedge clk) begin
    if (out_ld) begin
      out_r.status        <= status_r;
      out_r.result_value  <= val_r;
      out_r.result_high   <= hi_r;
      out_r.flags_word    <= flags_r;
      out_r.stack_pointer <= esp_r;
    end
  end

  assign empty    = !ovalid_r;
  assign out_data = out_r;

endmodule
`default_nettype wire

[hdl/toy_x86_alu_stack_executor.sv]
`default_nettype none
// Channel   | Ports                     | Beat taken when
// ----------+---------------------------+-------------------------
// input     | push, full, in_data       | push high, full low
// result    | empty, pop, out_data      | pop high, empty low
//
// One result beat per input beat, in order. From the head of the queue to the
// result register every item passes the read and execute states; mul then
// writes eax and edx, div (not by zero) waits on the 32-step restoring divider
// and then writes eax and edx, and push and pop reduce esp modulo MEM_BYTES by
// reciprocal multiplication, then move one stack byte a cycle.
// After reset a clearing pass over every stack address zeroes the stack and the
// register memory; full stays high through it. Synchronous active-low reset.
// A two-beat queue takes input while the back end works or waits on pop.
module toy_x86_alu_stack_executor #(
  parameter int unsigned MEM_BYTES = ttx_pkg::MEM_BYTES_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  output logic                    full,
  input  wire ttx_pkg::in_item_t  in_data,
  output logic                    empty,
  input  wire logic               pop,
  output ttx_pkg::out_item_t      out_data
);

  ttx_pkg::q_head_t    head;
  ttx_pkg::back_stat_t stat;
  logic                head_pop;

  // front: classify the beat and hold it in the queue
  ttx_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .hold     (stat.clearing),
    .full     (full),
    .in_data  (in_data),
    .head     (head),
    .head_pop (head_pop)
  );

  // back: registers, flags, stack, divider and result register
  ttx_back #(
    .MEM_BYTES (MEM_BYTES)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .head     (head),
    .head_pop (head_pop),
    .stat     (stat),
    .empty    (empty),
    .pop      (pop),
    .out_data (out_data)
  );

  // no beat enters while the memories are being cleared
  a_clear_holds: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> full)
    else $error("input open during clearing pass");

  // a waiting result is never dropped
  a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> !empty)
    else $error("result lost without pop");

  // the divider is never running while memories are cleared
  a_div_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !stat.div_busy)
    else $error("divider busy during clearing pass");

endmodule
`default_nettype wire

[sim/toy_x86_alu_stack_executor_checker.sv]
module toy_x86_alu_stack_executor_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  input  logic                        full,
  input  ttx_pkg::in_item_t           in_data,
  input  logic                        empty,
  input  logic                        pop,
  input  ttx_pkg::out_item_t          out_data,
  output int                          fail_count,
  output int                          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAW = $clog2(ttx_pkg::MEM_BYTES_DEF);

  logic [31:0]        regs [9];
  logic [31:0]        flags;
  logic [7:0]         stack_mem [ttx_pkg::MEM_BYTES_DEF];
  ttx_pkg::out_item_t awaited_q [$];

  function automatic logic [31:0] rd(logic [3:0] idx);
    return (idx < 9) ? regs[idx] : 32'd0;
  endfunction

  function automatic void wr(logic isr, logic [3:0] idx, logic [31:0] v);
    if (isr && idx < 9) regs[idx] = v;
  endfunction

  function automatic void upd_flags(logic [31:0] r);
    flags = flags & ~ttx_pkg::FLAG_CLEAR_MASK;
    if (r == 0) flags = flags | ttx_pkg::FLAG_ZF;
    if (r[31]) flags = flags | ttx_pkg::FLAG_SF;
    if (!(^r[7:0])) flags = flags | ttx_pkg::FLAG_PF;
  endfunction

  function automatic ttx_pkg::out_item_t execute(ttx_pkg::in_item_t it);
    ttx_pkg::out_item_t o;
    logic [31:0] a, b, sp;
    logic [63:0] prod;
    a = it.first_is_register ? rd(it.first_register) : it.first_immediate;
    b = it.second_is_register ? rd(it.second_register) : it.second_immediate;
    o = '0;
    regs[ttx_pkg::REG_EIP] = regs[ttx_pkg::REG_EIP] + 32'd1;
    case (it.action)
      ttx_pkg::OP_MOV: begin
        o.result_value = b; wr(it.first_is_register, it.first_register, b);
      end
      ttx_pkg::OP_ADD, ttx_pkg::OP_SUB, ttx_pkg::OP_CMP, ttx_pkg::OP_AND, ttx_pkg::OP_TEST,
      ttx_pkg::OP_OR, ttx_pkg::OP_XOR, ttx_pkg::OP_SHL, ttx_pkg::OP_SHR, ttx_pkg::OP_INC,
      ttx_pkg::OP_DEC: begin
        case (it.action)
          ttx_pkg::OP_ADD:                   o.result_value = a + b;
          ttx_pkg::OP_SUB, ttx_pkg::OP_CMP:  o.result_value = a - b;
          ttx_pkg::OP_AND, ttx_pkg::OP_TEST: o.result_value = a & b;
          ttx_pkg::OP_OR:                    o.result_value = a | b;
          ttx_pkg::OP_XOR:                   o.result_value = a ^ b;
          ttx_pkg::OP_SHL:                   o.result_value = a << b[4:0];
          ttx_pkg::OP_SHR:                   o.result_value = a >> b[4:0];
          ttx_pkg::OP_INC:                   o.result_value = a + 32'd1;
          default:                           o.result_value = a - 32'd1;
        endcase
        upd_flags(o.result_value);
        if ((it.action == ttx_pkg::OP_SUB || it.action == ttx_pkg::OP_CMP) && a < b)
          flags = flags | ttx_pkg::FLAG_CF;
        if (it.action != ttx_pkg::OP_CMP && it.action != ttx_pkg::OP_TEST)
          wr(it.first_is_register, it.first_register, o.result_value);
      end
      ttx_pkg::OP_MUL: begin
        prod = {32'd0, a} * {32'd0, b};
        o.result_value = prod[31:0]; o.result_high = prod[63:32];
        regs[ttx_pkg::REG_EAX] = prod[31:0]; regs[ttx_pkg::REG_EDX] = prod[63:32];
      end
      ttx_pkg::OP_DIV: begin
        if (b == 0) o.status = ttx_pkg::STAT_DIVZ;
        else begin
          o.result_value = a / b; o.result_high = a % b;
          regs[ttx_pkg::REG_EAX] = o.result_value; regs[ttx_pkg::REG_EDX] = o.result_high;
        end
      end
      ttx_pkg::OP_NOT: begin
        o.result_value = ~a; wr(it.first_is_register, it.first_register, ~a);
      end
      ttx_pkg::OP_PUSH: begin
        regs[ttx_pkg::REG_ESP] = regs[ttx_pkg::REG_ESP] - 32'd4;
        sp = regs[ttx_pkg::REG_ESP];
        for (int k = 0; k < 4; k++)
          stack_mem[SAW'((sp + 32'(k)) % ttx_pkg::MEM_BYTES_DEF)] = a[8*k +: 8];
        o.result_value = a;
      end
      ttx_pkg::OP_POP: begin
        sp = regs[ttx_pkg::REG_ESP];
        for (int k = 0; k < 4; k++)
          o.result_value[8*k +: 8] = stack_mem[SAW'((sp + 32'(k)) % ttx_pkg::MEM_BYTES_DEF)];
        regs[ttx_pkg::REG_ESP] = sp + 32'd4;
        wr(it.first_is_register, it.first_register, o.result_value);
      end
      ttx_pkg::OP_NOP: ;
      default: o.status = ttx_pkg::STAT_UNK;
    endcase
    o.flags_word = flags;
    o.stack_pointer = regs[ttx_pkg::REG_ESP];
    return o;
  endfunction

  always @(posedge clk) begin
    ttx_pkg::out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < 9; i++) regs[i] = '0;
      regs[ttx_pkg::REG_ESP] = ttx_pkg::ESP_RESET;
      flags = ttx_pkg::FLAGS_RESET;
      for (int i = 0; i < ttx_pkg::MEM_BYTES_DEF; i++) stack_mem[i] = '0;
      awaited_q.delete();
      fail_count = 0;
    end else begin
      if (push && !full) awaited_q.push_back(execute(in_data));
      if (pop && !empty) begin
        if (awaited_q.size() == 0) begin
          $error("result beat with nothing awaited");
          fail_count++;
        end else begin
          want = awaited_q.pop_front();
          if (out_data.status !== want.status) begin
            $error("status exp %0d got %0d", want.status, out_data.status); fail_count++;
          end
          if (out_data.result_value !== want.result_value) begin
            $error("result_value exp %h got %h", want.result_value, out_data.result_value);
            fail_count++;
          end
          if (out_data.result_high !== want.result_high) begin
            $error("result_high exp %h got %h", want.result_high, out_data.result_high);
            fail_count++;
          end
          if (out_data.flags_word !== want.flags_word) begin
            $error("flags_word exp %h got %h", want.flags_word, out_data.flags_word);
            fail_count++;
          end
          if (out_data.stack_pointer !== want.stack_pointer) begin
            $error("stack_pointer exp %h got %h", want.stack_pointer, out_data.stack_pointer);
            fail_count++;
          end
        end
      end
    end
    pending = awaited_q.size();
  end
endmodule

[sim/toy_x86_alu_stack_executor_tb.sv]
module toy_x86_alu_stack_executor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               push = 1'b0;
  logic               pop = 1'b0;
  logic               full, empty;
  ttx_pkg::in_item_t  in_data = '0;
  ttx_pkg::out_item_t out_data;
  int                 fail_count, pending;
  int                 cycles = 0;

  // worst case: the slowest beat plus long gaps on both sides, many times over
  localparam int CYCLE_LIMIT = 1000000;

  always #4 clk = ~clk;

  toy_x86_alu_stack_executor uut (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data)
  );

  toy_x86_alu_stack_executor_checker chk (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_data(in_data),
    .empty(empty), .pop(pop), .out_data(out_data),
    .fail_count(fail_count), .pending(pending)
  );

  // mostly short gaps, now and then a long one
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // edge-heavy operand value
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2: return 32'h8000_0000;
      3: return $urandom_range(0, 40);
      default: return $urandom();
    endcase
  endfunction

  function automatic ttx_pkg::in_item_t rand_item();
    ttx_pkg::in_item_t it;
    int r;
    r = $urandom_range(0, 99);
    // mostly legal actions, weighted a little towards the stack ops
    if (r < 6) it.action = 5'($urandom_range(18, 31));
    else if (r < 20) it.action = $urandom_range(0, 1) ? ttx_pkg::OP_PUSH : ttx_pkg::OP_POP;
    else it.action = 5'($urandom_range(0, 17));
    it.first_is_register  = ($urandom_range(0, 3) != 0);
    it.first_register     = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                           : $urandom_range(0, 8));
    it.first_immediate    = pick_value();
    it.second_is_register = 1'($urandom_range(0, 1));
    it.second_register    = 4'(($urandom_range(0, 9) == 0) ? $urandom_range(9, 15)
                                                           : $urandom_range(0, 8));
    it.second_immediate   = pick_value();
    return it;
  endfunction

  function automatic ttx_pkg::in_item_t mk(int a, int r1, int i1, logic [31:0] v1,
                                           int r2, int i2, logic [31:0] v2);
    ttx_pkg::in_item_t it;
    it.action = 5'(a); it.first_is_register = 1'(r1); it.first_register = 4'(i1);
    it.first_immediate = v1; it.second_is_register = 1'(r2); it.second_register = 4'(i2);
    it.second_immediate = v2;
    return it;
  endfunction

  // hold the beat until it is taken, then idle for a random gap
  task automatic send_beat(ttx_pkg::in_item_t it);
    int g;
    in_data <= it;
    push <= 1'b1;
    do @(posedge clk); while (full);
    g = gap_len();
    @(negedge clk);
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("toy_x86_alu_stack_executor_tb: errors");
      $finish;
    end
  end

  // result side: pop with random stalls
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < 70) pop <= 1'b1;
      else begin
        pop <= 1'b0;
        repeat (gap_len()) @(negedge clk);
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // directed: extremes, every action, special cases
    send_beat(mk(ttx_pkg::OP_MOV, 1, 0, 0, 0, 0, 32'hFFFF_FFFF));
    send_beat(mk(ttx_pkg::OP_ADD, 1, 0, 0, 0, 0, 32'd1));          // wrap to zero
    send_beat(mk(ttx_pkg::OP_SUB, 1, 1, 0, 0, 0, 32'd1));          // borrow
    send_beat(mk(ttx_pkg::OP_MOV, 1, 2, 0, 0, 0, 32'hFFFF_FFFF));
    send_beat(mk(ttx_pkg::OP_MUL, 1, 2, 0, 1, 2, 0));
    send_beat(mk(ttx_pkg::OP_DIV, 0, 0, 32'hFFFF_FFFF, 0, 0, 32'd7));
    send_beat(mk(ttx_pkg::OP_DIV, 1, 0, 0, 0, 0, 32'd0));          // division by zero
    send_beat(mk(ttx_pkg::OP_AND, 1, 3, 0, 0, 0, 32'h8000_00FF));
    send_beat(mk(ttx_pkg::OP_OR, 0, 0, 32'h1234_5678, 0, 0, 32'd0)); // no write back
    send_beat(mk(ttx_pkg::OP_XOR, 1, 4, 0, 1, 4, 0));
    send_beat(mk(ttx_pkg::OP_NOT, 1, 4, 0, 0, 0, 0));
    send_beat(mk(ttx_pkg::OP_SHL, 1, 4, 0, 0, 0, 32'd33));         // count masked
    send_beat(mk(ttx_pkg::OP_SHR, 1, 4, 0, 0, 0, 32'd31));
    send_beat(mk(ttx_pkg::OP_INC, 1, 15, 0, 0, 0, 0));             // out-of-range register
    send_beat(mk(ttx_pkg::OP_DEC, 1, 5, 0, 1, 12, 0));
    send_beat(mk(ttx_pkg::OP_CMP, 1, 5, 0, 0, 0, 32'd5));
    send_beat(mk(ttx_pkg::OP_TEST, 1, 6, 0, 1, 5, 0));
    send_beat(mk(ttx_pkg::OP_PUSH, 1, 5, 0, 0, 0, 0));             // push from a register
    send_beat(mk(ttx_pkg::OP_PUSH, 0, 0, 32'hA5A5_5A5A, 0, 0, 0));
    send_beat(mk(ttx_pkg::OP_POP, 1, 1, 0, 0, 0, 0));
    send_beat(mk(ttx_pkg::OP_POP, 1, 7, 0, 0, 0, 0));              // pop into esp
    send_beat(mk(ttx_pkg::OP_MOV, 1, 8, 0, 0, 0, 32'd100));        // write eip
    send_beat(mk(ttx_pkg::OP_NOP, 1, 8, 0, 1, 8, 0));
    send_beat(mk(31, 1, 0, 0, 0, 0, 0));                           // unknown action
    send_beat(mk(18, 0, 0, 32'hFFFF_FFFF, 1, 15, 0));
    // random part
    repeat (1700) send_beat(rand_item());
    push <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) $display("toy_x86_alu_stack_executor_tb: clean");
    else $display("toy_x86_alu_stack_executor_tb: errors");
    $finish;
  end
endmodule
